// ===== rtl/stok_pkg.sv =====
// Shared types, codes and keyword tables for the script tokenizer.
// No dependencies; imported by stok_core and script_tokenizer_unit.
package stok_pkg;

  // Scan modes
  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_NUM   = 4'd1;
  localparam logic [3:0] M_SQ    = 4'd2;
  localparam logic [3:0] M_DQ    = 4'd3;
  localparam logic [3:0] M_ID    = 4'd4;
  localparam logic [3:0] M_LINE  = 4'd5;
  localparam logic [3:0] M_BLOCK = 4'd6;

  // Pending operator codes
  localparam logic [3:0] P_NONE  = 4'd0;
  localparam logic [3:0] P_EQ    = 4'd1;
  localparam logic [3:0] P_PLUS  = 4'd2;
  localparam logic [3:0] P_MINUS = 4'd3;
  localparam logic [3:0] P_STAR  = 4'd4;
  localparam logic [3:0] P_STAR2 = 4'd5;
  localparam logic [3:0] P_SLASH = 4'd6;
  localparam logic [3:0] P_PCT   = 4'd7;
  localparam logic [3:0] P_GT    = 4'd8;
  localparam logic [3:0] P_LT    = 4'd9;
  localparam logic [3:0] P_BANG  = 4'd10;
  localparam logic [3:0] P_AMP   = 4'd11;
  localparam logic [3:0] P_BAR   = 4'd12;
  localparam logic [3:0] P_DOT   = 4'd13;

  // Result item kinds
  localparam logic [1:0] IK_LEX = 2'd0;
  localparam logic [1:0] IK_TOK = 2'd1;
  localparam logic [1:0] IK_ERR = 2'd2;

  // Token kinds that the logic names directly
  localparam logic [5:0] TK_END    = 6'd0;
  localparam logic [5:0] TK_NUMBER = 6'd1;
  localparam logic [5:0] TK_STRING = 6'd2;
  localparam logic [5:0] TK_NULL   = 6'd3;
  localparam logic [5:0] TK_BOOL   = 6'd4;
  localparam logic [5:0] TK_IDENT  = 6'd5;
  localparam logic [5:0] TK_IF     = 6'd6;
  localparam logic [5:0] TK_ELIF   = 6'd7;
  localparam logic [5:0] TK_ELSE   = 6'd8;
  localparam logic [5:0] TK_LBRACE = 6'd11;
  localparam logic [5:0] TK_RBRACE = 6'd12;
  localparam logic [5:0] TK_LPAREN = 6'd13;
  localparam logic [5:0] TK_RPAREN = 6'd14;
  localparam logic [5:0] TK_COMMA  = 6'd15;
  localparam logic [5:0] TK_SEMI   = 6'd16;
  localparam logic [5:0] TK_ANDAND = 6'd35;
  localparam logic [5:0] TK_OROR   = 6'd36;

  localparam int unsigned NUM_KW = 7;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] tok;
    logic       bv;
    logic [7:0] lbyte;
  } item_t;

  typedef struct packed {
    logic [1:0]      cnt;
    item_t [1:0]     it;
  } list_t;

  function automatic item_t mk_item(logic [1:0] kind, logic [5:0] tok, logic bv,
                                    logic [7:0] lbyte);
    item_t r;
    r.kind  = kind;
    r.tok   = tok;
    r.bv    = bv;
    r.lbyte = lbyte;
    return r;
  endfunction

  // Append one item; drop anything beyond two
  function automatic list_t push(list_t l, item_t x);
    list_t r;
    r = l;
    if (l.cnt == 2'd0) begin
      r.it[0] = x;
      r.cnt   = 2'd1;
    end else if (l.cnt == 2'd1) begin
      r.it[1] = x;
      r.cnt   = 2'd2;
    end
    return r;
  endfunction

  function automatic logic [5:0] op_alone(logic [3:0] p);
    logic [5:0] r;
    case (p)
      P_EQ:    r = 6'd9;
      P_PLUS:  r = 6'd17;
      P_MINUS: r = 6'd19;
      P_STAR:  r = 6'd21;
      P_STAR2: r = 6'd23;
      P_SLASH: r = 6'd25;
      P_PCT:   r = 6'd27;
      P_GT:    r = 6'd29;
      P_LT:    r = 6'd31;
      P_BANG:  r = 6'd33;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] op_assign(logic [3:0] p);
    logic [5:0] r;
    case (p)
      P_EQ:    r = 6'd10;
      P_PLUS:  r = 6'd18;
      P_MINUS: r = 6'd20;
      P_STAR:  r = 6'd22;
      P_STAR2: r = 6'd24;
      P_SLASH: r = 6'd26;
      P_PCT:   r = 6'd28;
      P_GT:    r = 6'd30;
      P_LT:    r = 6'd32;
      P_BANG:  r = 6'd34;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // Keywords in order: null true false if elif elseif else
  function automatic logic [2:0] kw_len(logic [2:0] k);
    logic [2:0] r;
    case (k)
      3'd0:    r = 3'd4;
      3'd1:    r = 3'd4;
      3'd2:    r = 3'd5;
      3'd3:    r = 3'd2;
      3'd4:    r = 3'd4;
      3'd5:    r = 3'd6;
      3'd6:    r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] kw_tok(logic [2:0] k);
    logic [5:0] r;
    case (k)
      3'd0:    r = TK_NULL;
      3'd1:    r = TK_BOOL;
      3'd2:    r = TK_BOOL;
      3'd3:    r = TK_IF;
      3'd4:    r = TK_ELIF;
      3'd5:    r = TK_ELIF;
      3'd6:    r = TK_ELSE;
      default: r = TK_IDENT;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(logic [2:0] k, logic [2:0] pos);
    logic [7:0] r;
    r = 8'd0;
    case (k)
      3'd0: case (pos)
        3'd0: r = "n"; 3'd1: r = "u"; 3'd2: r = "l"; 3'd3: r = "l";
        default: r = 8'd0;
      endcase
      3'd1: case (pos)
        3'd0: r = "t"; 3'd1: r = "r"; 3'd2: r = "u"; 3'd3: r = "e";
        default: r = 8'd0;
      endcase
      3'd2: case (pos)
        3'd0: r = "f"; 3'd1: r = "a"; 3'd2: r = "l"; 3'd3: r = "s"; 3'd4: r = "e";
        default: r = 8'd0;
      endcase
      3'd3: case (pos)
        3'd0: r = "i"; 3'd1: r = "f";
        default: r = 8'd0;
      endcase
      3'd4: case (pos)
        3'd0: r = "e"; 3'd1: r = "l"; 3'd2: r = "i"; 3'd3: r = "f";
        default: r = 8'd0;
      endcase
      3'd5: case (pos)
        3'd0: r = "e"; 3'd1: r = "l"; 3'd2: r = "s"; 3'd3: r = "e"; 3'd4: r = "i";
        3'd5: r = "f";
        default: r = 8'd0;
      endcase
      3'd6: case (pos)
        3'd0: r = "e"; 3'd1: r = "l"; 3'd2: r = "s"; 3'd3: r = "e";
        default: r = 8'd0;
      endcase
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage

// ===== rtl/stok_core.sv =====
// Lexer state register and the next-state/result logic for one input word.
// Depends on stok_pkg.
module stok_core import stok_pkg::*; #(
  parameter int unsigned MAX_LEXEME = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] ch_i,
  input  logic       eot_i,
  output list_t      res_o
);

  localparam int unsigned LW = $clog2(MAX_LEXEME);
  localparam logic [LW-1:0] LEN_LIMIT = LW'(MAX_LEXEME - 1);

  typedef struct packed {
    logic [3:0]    mode;
    logic [3:0]    pend;
    logic [7:0]    prev;
    logic [LW-1:0] len;
    logic [6:0]    cand;
    logic          esc;
    logic          halt;
  } lex_state_t;

  typedef struct packed {
    lex_state_t s;
    list_t      l;
  } step_t;

  function automatic lex_state_t reset_state();
    lex_state_t s;
    s.mode = M_IDLE;
    s.pend = P_NONE;
    s.prev = 8'd0;
    s.len  = '0;
    s.cand = 7'h7F;
    s.esc  = 1'b0;
    s.halt = 1'b0;
    return s;
  endfunction

  function automatic step_t fail(step_t r);
    step_t o;
    o = r;
    o.l      = push(o.l, mk_item(IK_ERR, TK_END, 1'b0, 8'd0));
    o.s.halt = 1'b1;
    o.s.mode = M_IDLE;
    o.s.pend = P_NONE;
    return o;
  endfunction

  function automatic step_t start_lex(step_t r, logic [3:0] mode);
    step_t o;
    o = r;
    o.s.mode = mode;
    o.s.len  = '0;
    o.s.cand = 7'h7F;
    o.s.esc  = 1'b0;
    return o;
  endfunction

  function automatic step_t lex_byte(step_t r, logic [7:0] c);
    step_t o;
    o = r;
    if (r.s.len >= LEN_LIMIT) begin
      o = fail(r);
    end else begin
      o.l     = push(o.l, mk_item(IK_LEX, TK_END, 1'b0, c));
      o.s.len = r.s.len + 1'b1;
    end
    return o;
  endfunction

  function automatic step_t ident_byte(step_t r, logic [7:0] c);
    step_t o;
    o = r;
    for (int k = 0; k < NUM_KW; k++) begin
      if ((r.s.len >= LW'(kw_len(3'(k)))) || (kw_char(3'(k), r.s.len[2:0]) != c)) begin
        o.s.cand[k] = 1'b0;
      end
    end
    return lex_byte(o, c);
  endfunction

  function automatic step_t finish_ident(step_t r);
    step_t o;
    logic  found;
    o = r;
    found = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!found && r.s.cand[k] && (r.s.len == LW'(kw_len(3'(k))))) begin
        found = 1'b1;
        o.l   = push(o.l, mk_item(IK_TOK, kw_tok(3'(k)), (k == 1), 8'd0));
      end
    end
    if (!found) begin
      o.l = push(o.l, mk_item(IK_TOK, TK_IDENT, 1'b0, 8'd0));
    end
    return o;
  endfunction

  function automatic step_t emit_tok(step_t r, logic [5:0] tok);
    step_t o;
    o = r;
    o.l = push(o.l, mk_item(IK_TOK, tok, 1'b0, 8'd0));
    return o;
  endfunction

  function automatic step_t idle_byte(step_t r, logic [7:0] c);
    step_t o;
    o = r;
    o.s.mode = M_IDLE;
    if (is_digit(c)) begin
      o = lex_byte(start_lex(o, M_NUM), c);
      o.s.prev = c;
    end else if (is_alpha(c) || (c == "_")) begin
      o = ident_byte(start_lex(o, M_ID), c);
    end else begin
      case (c)
        8'h27:   o = start_lex(o, M_SQ);
        8'h22:   o = start_lex(o, M_DQ);
        ".":     o.s.pend = P_DOT;
        "{":     o = emit_tok(o, TK_LBRACE);
        "}":     o = emit_tok(o, TK_RBRACE);
        "(":     o = emit_tok(o, TK_LPAREN);
        ")":     o = emit_tok(o, TK_RPAREN);
        ",":     o = emit_tok(o, TK_COMMA);
        ";":     o = emit_tok(o, TK_SEMI);
        "=":     o.s.pend = P_EQ;
        "+":     o.s.pend = P_PLUS;
        "-":     o.s.pend = P_MINUS;
        "*":     o.s.pend = P_STAR;
        "/":     o.s.pend = P_SLASH;
        "%":     o.s.pend = P_PCT;
        ">":     o.s.pend = P_GT;
        "<":     o.s.pend = P_LT;
        "!":     o.s.pend = P_BANG;
        "&":     o.s.pend = P_AMP;
        "|":     o.s.pend = P_BAR;
        "#":     o.s.mode = M_LINE;
        default: if (!is_space(c)) o = fail(o);
      endcase
    end
    return o;
  endfunction

  function automatic step_t resolve_pending(step_t r, logic [7:0] c);
    step_t      o;
    logic [3:0] p;
    o = r;
    p = r.s.pend;
    o.s.pend = P_NONE;
    if (p == P_DOT) begin
      if (is_digit(c)) begin
        o = lex_byte(lex_byte(start_lex(o, M_NUM), "."), c);
        o.s.prev = c;
      end else begin
        o = fail(o);
      end
    end else if (p == P_AMP) begin
      o = (c == "&") ? emit_tok(o, TK_ANDAND) : fail(o);
    end else if (p == P_BAR) begin
      o = (c == "|") ? emit_tok(o, TK_OROR) : fail(o);
    end else if ((p == P_STAR) && (c == "*")) begin
      o.s.pend = P_STAR2;
    end else if ((p == P_SLASH) && (c == "/")) begin
      o.s.mode = M_LINE;
    end else if ((p == P_SLASH) && (c == "*")) begin
      o.s.mode = M_BLOCK;
      o.s.prev = 8'd0;
    end else if (c == "=") begin
      o = emit_tok(o, op_assign(p));
    end else begin
      o = idle_byte(emit_tok(o, op_alone(p)), c);
    end
    return o;
  endfunction

  function automatic step_t text_byte(step_t r, logic [7:0] c);
    step_t o;
    o = r;
    if (r.s.pend != P_NONE) begin
      o = resolve_pending(r, c);
    end else begin
      case (r.s.mode)
        M_NUM: begin
          if (is_digit(c) || (c == ".") || (c == "e") || (c == "E") ||
              ((c == "-") && ((r.s.prev == "e") || (r.s.prev == "E")))) begin
            o = lex_byte(r, c);
            o.s.prev = c;
          end else begin
            o = idle_byte(emit_tok(r, TK_NUMBER), c);
          end
        end
        M_SQ, M_DQ: begin
          if (r.s.esc) begin
            o.s.esc = 1'b0;
            if ((c == 8'h5C) || (c == 8'h27) || (c == 8'h22)) o = lex_byte(o, c);
          end else if (c == 8'h5C) begin
            o.s.esc = 1'b1;
          end else if (c == ((r.s.mode == M_SQ) ? 8'h27 : 8'h22)) begin
            o = emit_tok(r, TK_STRING);
            o.s.mode = M_IDLE;
          end else begin
            o = lex_byte(r, c);
          end
        end
        M_ID: begin
          if (is_alpha(c) || is_digit(c) || (c == "_")) o = ident_byte(r, c);
          else o = idle_byte(finish_ident(r), c);
        end
        M_LINE: begin
          if ((c == 8'h0D) || (c == 8'h0A)) o.s.mode = M_IDLE;
        end
        M_BLOCK: begin
          if ((r.s.prev == "*") && (c == "/")) o.s.mode = M_IDLE;
          else o.s.prev = c;
        end
        default: o = idle_byte(r, c);
      endcase
    end
    return o;
  endfunction

  function automatic list_t finish_text(step_t r);
    step_t o;
    logic  stop;
    o = r;
    stop = 1'b0;
    if (r.s.halt) begin
      stop = 1'b1;
    end else if (r.s.pend != P_NONE) begin
      if ((r.s.pend == P_DOT) || (r.s.pend == P_AMP) || (r.s.pend == P_BAR)) begin
        o = fail(o);
        stop = 1'b1;
      end else begin
        o = emit_tok(o, op_alone(r.s.pend));
      end
    end else if (r.s.mode == M_NUM) begin
      o = emit_tok(o, TK_NUMBER);
    end else if (r.s.mode == M_ID) begin
      o = finish_ident(o);
    end else if ((r.s.mode == M_SQ) || (r.s.mode == M_DQ)) begin
      o = fail(o);
      stop = 1'b1;
    end
    if (!stop) o = emit_tok(o, TK_END);
    return o.l;
  endfunction

  lex_state_t state_q, state_d;
  step_t      cur, nxt;

  always_comb begin
    cur.s      = state_q;
    cur.l      = '0;
    nxt        = cur;
    if (eot_i) begin
      nxt.l = finish_text(cur);
      nxt.s = reset_state();
    end else if (!state_q.halt) begin
      nxt = text_byte(cur, ch_i);
    end
    state_d = step_i ? nxt.s : state_q;
    res_o   = nxt.l;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= reset_state();
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/script_tokenizer_unit.sv =====
// Streaming lexer top level: lexer core plus a four-word result queue.
// Depends on stok_pkg and stok_core.
//
//   channel  direction  handshake              payload
//   input    in         in_valid_i/in_stall_o  ch_i, end_of_text_i
//   output   out        out_valid_o/out_stall_i item_kind_o, token_kind_o,
//                                               bool_value_o, lexeme_byte_o, last_o
//
// One input word is taken per cycle while in_stall_o is low; the lexer state updates at that edge and the
// zero, one or two result words it causes enter the queue at the same edge.
// Results appear in the cycle after acceptance at the earliest, one per cycle while out_stall_i is low.
// The queue holds four words; input stalls while fewer than two slots are free,
// so the sustained rate is set by the output side draining one word a cycle while out_stall_i is low.
// Reset returns the lexer to between-tokens and empties the queue.
module script_tokenizer_unit import stok_pkg::*; #(
  parameter int unsigned MAX_LEXEME = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] item_kind_o,
  output logic [5:0] token_kind_o,
  output logic       bool_value_o,
  output logic [7:0] lexeme_byte_o,
  output logic       last_o
);

  localparam int unsigned QD = 4;

  typedef struct packed {
    item_t it;
    logic  last;
  } qword_t;

  logic   in_acc, out_acc;
  list_t  res;
  qword_t q_mem [QD];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;

  // Hold input whenever two more words might not fit
  assign in_stall_o = (cnt_q > 3'd2);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_acc    = out_valid_o && !out_stall_i;

  stok_core #(.MAX_LEXEME(MAX_LEXEME)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_acc),
    .ch_i   (ch_i),
    .eot_i  (end_of_text_i),
    .res_o  (res)
  );

  logic [2:0] push_n;
  assign push_n = in_acc ? {1'b0, res.cnt} : 3'd0;
  assign cnt_d  = cnt_q + push_n - {2'b0, out_acc};

  // Write the new words; mark the final one of this input
  always_ff @(posedge clk_i) begin
    if (in_acc && (res.cnt != 2'd0)) begin
      q_mem[wr_q] <= '{it: res.it[0], last: (res.cnt == 2'd1)};
    end
    if (in_acc && (res.cnt == 2'd2)) begin
      q_mem[wr_q + 2'd1] <= '{it: res.it[1], last: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_q + push_n[1:0];
      if (out_acc) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_d;
    end
  end

  qword_t head;
  assign head          = q_mem[rd_q];
  assign item_kind_o   = head.it.kind;
  assign token_kind_o  = head.it.tok;
  assign bool_value_o  = head.it.bv;
  assign lexeme_byte_o = head.it.lbyte;
  assign last_o        = head.last;

endmodule
